/* hw/rtl/wmf_pkg.sv */
package wmf_pkg;

	// Geometry limits
	localparam int MAX_RADIUS  = 3;
	localparam int MAX_WIDTH   = 1024;
	localparam int LAG_MAX     = MAX_RADIUS * MAX_WIDTH + MAX_RADIUS;
	localparam int STORE_DEPTH = 2 * LAG_MAX + 1;
	localparam int PTR_W       = $clog2(STORE_DEPTH);
	localparam int WIN_SIDE    = 2 * MAX_RADIUS + 1;
	localparam int WIN_CELLS   = WIN_SIDE * WIN_SIDE;

	// Field and counter widths
	localparam int PIX_W      = 8;
	localparam int WIDTH_W    = 11;
	localparam int HEIGHT_W   = 16;
	localparam int RADIUS_W   = 2;
	localparam int RAD_W      = $clog2(MAX_RADIUS + 1);
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int PEND_W     = $clog2(LAG_MAX + 2);
	localparam int SUM_W      = PTR_W + 2;
	localparam int GATHER_W   = $clog2(WIN_SIDE);
	localparam int PART_W     = $clog2(WIN_SIDE + 1);
	localparam int CNT_W      = $clog2(WIN_CELLS + 1);
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Output queue
	localparam int FIFO_DEPTH = 16;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	// Register reset values
	localparam logic [WIDTH_W-1:0]  WIDTH_RST  = WIDTH_W'(640);
	localparam logic [HEIGHT_W-1:0] HEIGHT_RST = HEIGHT_W'(480);
	localparam logic [RADIUS_W-1:0] RADIUS_RST = RADIUS_W'(1);

	// Input item kinds
	localparam logic MODE_PIXEL = 1'b0;
	localparam logic MODE_FLUSH = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WIDTH  = 2'd0,
		CFG_HEIGHT = 2'd1,
		CFG_RADIUS = 2'd2
	} cfg_idx_t;

	typedef logic [PIX_W-1:0] pix_t;

	// One window column, row dr = -MAX_RADIUS at index 0
	typedef logic [WIN_SIDE-1:0][PIX_W-1:0] col_t;

	// Tag that travels with each output request
	typedef struct packed {
		logic valid;
		logic border;
		logic last;
	} tag_t;

endpackage

/* hw/rtl/window_mode_filter.sv */
// Streaming 2-D mode filter for 8-bit raster frames. One request (pixel or flush tick) is
// taken per clock while in_stall is low; each output pixel leaves the mode stages into a
// 16-entry output queue and waits there. The window is a row of seven column registers fed
// by seven copies of the line store (one read port each), so a normal output costs one
// column read. When the cached columns may be stale (first output after reset, after any
// register write, or after a pixel lands inside the region still to be read, as after a
// flush), that output reloads all 2r+1 columns and input stalls while the reload runs.
// The line store holds 2*(3*1024+3)+1 pixels per copy and needs no clearing.
module window_mode_filter (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [wmf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [wmf_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             mode,
	input  logic [wmf_pkg::PIX_W-1:0]        pixel,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [wmf_pkg::PIX_W-1:0]        out_pixel,
	output logic                             out_last
);

	localparam int SW = wmf_pkg::SUM_W;

	logic [wmf_pkg::WIDTH_W-1:0]   width_q;
	logic [wmf_pkg::HEIGHT_W-1:0]  height_q;
	logic [wmf_pkg::RADIUS_W-1:0]  radius_q;
	logic [wmf_pkg::WIDTH_W-1:0]   w_eff;
	logic [wmf_pkg::HEIGHT_W-1:0]  h_eff;
	logic [wmf_pkg::RAD_W-1:0]     r_eff;
	logic [wmf_pkg::PEND_W-1:0]    delay;
	logic                          cfg_fire;

	logic [wmf_pkg::PTR_W-1:0]     wr_q;
	logic [wmf_pkg::PEND_W-1:0]    pend_q;
	logic [wmf_pkg::COL_W-1:0]     col_q;
	logic [wmf_pkg::HEIGHT_W-1:0]  row_q;
	logic                          invalid_q;
	logic [wmf_pkg::FIFO_AW:0]     outst_q;

	logic                          in_fire;
	logic                          is_data;
	logic [wmf_pkg::PEND_W-1:0]    pend_inc;
	logic                          emit;
	logic                          emit_fire;
	logic [SW-1:0]                 csum;
	logic [SW-1:0]                 cwrap;
	logic                          interior;
	logic                          frame_last;
	logic [wmf_pkg::WIDTH_W-1:0]   col_p1;
	logic [wmf_pkg::HEIGHT_W:0]    row_p1;

	logic                          s1_valid;
	logic [wmf_pkg::PTR_W-1:0]     s1_center;
	logic                          s1_border;
	logic                          s1_last;
	logic                          refill_q;
	logic [wmf_pkg::GATHER_W-1:0]  g_q;
	logic                          run;
	logic [wmf_pkg::GATHER_W-1:0]  g;
	logic                          g_last;
	logic                          s1_done;
	logic [SW-1:0]                 dc;

	wmf_pkg::col_t                 ram_col;
	wmf_pkg::col_t                 chain [wmf_pkg::WIN_SIDE];
	logic                          shift_s2;
	wmf_pkg::tag_t                 tag_s2;
	wmf_pkg::tag_t                 tag_s3;
	wmf_pkg::tag_t                 mode_tag;
	wmf_pkg::pix_t                 mode_value;

	wmf_pkg::pix_t                 fifo_pix_q [wmf_pkg::FIFO_DEPTH];
	logic                          fifo_last_q [wmf_pkg::FIFO_DEPTH];
	logic [wmf_pkg::FIFO_AW-1:0]   fwp_q;
	logic [wmf_pkg::FIFO_AW-1:0]   frp_q;
	logic [wmf_pkg::FIFO_AW:0]     fcnt_q;
	logic                          pop;

	// Configuration registers
	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= wmf_pkg::WIDTH_RST;
			height_q <= wmf_pkg::HEIGHT_RST;
			radius_q <= wmf_pkg::RADIUS_RST;
		end else if (cfg_fire) begin
			case (wmf_pkg::cfg_idx_t'(cfg_index))
				wmf_pkg::CFG_WIDTH:  width_q  <= cfg_data[wmf_pkg::WIDTH_W-1:0];
				wmf_pkg::CFG_HEIGHT: height_q <= cfg_data[wmf_pkg::HEIGHT_W-1:0];
				wmf_pkg::CFG_RADIUS: radius_q <= cfg_data[wmf_pkg::RADIUS_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp the registers to usable values
	always_comb begin
		if (width_q == '0) begin
			w_eff = wmf_pkg::WIDTH_W'(1);
		end else if (width_q > wmf_pkg::WIDTH_W'(wmf_pkg::MAX_WIDTH)) begin
			w_eff = wmf_pkg::WIDTH_W'(wmf_pkg::MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
		h_eff = (height_q == '0) ? wmf_pkg::HEIGHT_W'(1) : height_q;
		if (int'(radius_q) > wmf_pkg::MAX_RADIUS) begin
			r_eff = wmf_pkg::RAD_W'(wmf_pkg::MAX_RADIUS);
		end else begin
			r_eff = wmf_pkg::RAD_W'(radius_q);
		end
		delay = wmf_pkg::PEND_W'(r_eff) * wmf_pkg::PEND_W'(w_eff) + wmf_pkg::PEND_W'(r_eff);
	end

	// Request decode and output position
	assign in_fire   = in_valid && !in_stall;
	assign is_data   = (mode == wmf_pkg::MODE_PIXEL);
	assign pend_inc  = pend_q + wmf_pkg::PEND_W'(1);
	assign emit      = is_data ? (pend_inc > delay) : (pend_q != '0);
	assign emit_fire = in_fire && emit;
	assign csum      = SW'(wr_q) - SW'(pend_q);
	assign cwrap     = csum[SW-1] ? csum + SW'(wmf_pkg::STORE_DEPTH) : csum;

	assign interior = (row_q >= wmf_pkg::HEIGHT_W'(r_eff)) &&
		({1'b0, row_q} + (wmf_pkg::HEIGHT_W + 1)'(r_eff) < {1'b0, h_eff}) &&
		(col_q >= wmf_pkg::COL_W'(r_eff)) &&
		(wmf_pkg::WIDTH_W'(col_q) + wmf_pkg::WIDTH_W'(r_eff) < w_eff);
	assign frame_last = (row_q == h_eff - wmf_pkg::HEIGHT_W'(1)) &&
		(wmf_pkg::WIDTH_W'(col_q) == w_eff - wmf_pkg::WIDTH_W'(1));
	assign col_p1 = wmf_pkg::WIDTH_W'(col_q) + wmf_pkg::WIDTH_W'(1);
	assign row_p1 = {1'b0, row_q} + (wmf_pkg::HEIGHT_W + 1)'(1);

	// Write pointer, pending count and raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			pend_q <= '0;
			col_q  <= '0;
			row_q  <= '0;
		end else if (in_fire) begin
			if (is_data) begin
				wr_q <= (wr_q == wmf_pkg::PTR_W'(wmf_pkg::STORE_DEPTH - 1)) ?
					'0 : wr_q + wmf_pkg::PTR_W'(1);
				if (!emit) begin
					pend_q <= pend_inc;
				end
			end else if (emit) begin
				pend_q <= pend_q - wmf_pkg::PEND_W'(1);
			end
			if (emit) begin
				if (col_p1 >= w_eff) begin
					col_q <= '0;
					row_q <= (row_p1 >= {1'b0, h_eff}) ? '0 : row_p1[wmf_pkg::HEIGHT_W-1:0];
				end else begin
					col_q <= col_p1[wmf_pkg::COL_W-1:0];
				end
			end
		end
	end

	// Column fetch: one leading column, or a full reload when the cache is stale
	assign run     = invalid_q || refill_q;
	assign g       = refill_q ? g_q : '0;
	assign g_last  = !run || (g == (wmf_pkg::GATHER_W'(r_eff) << 1));
	assign s1_done = s1_valid && g_last;
	assign dc      = run ? SW'(g) - SW'(r_eff) : SW'(r_eff);

	assign in_stall = (s1_valid && !g_last) ||
		(outst_q == (wmf_pkg::FIFO_AW + 1)'(wmf_pkg::FIFO_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid  <= 1'b0;
			refill_q  <= 1'b0;
			g_q       <= '0;
			invalid_q <= 1'b1;
		end else begin
			if (emit_fire) begin
				s1_valid <= 1'b1;
			end else if (s1_done) begin
				s1_valid <= 1'b0;
			end
			if (s1_valid && !g_last) begin
				refill_q <= 1'b1;
				g_q      <= g + wmf_pkg::GATHER_W'(1);
			end else if (s1_done) begin
				refill_q <= 1'b0;
				g_q      <= '0;
			end
			// drop the cache on a register write or a pixel landing inside it
			if (cfg_fire || (in_fire && is_data && (pend_q < delay))) begin
				invalid_q <= 1'b1;
			end else if (s1_valid && invalid_q && !refill_q) begin
				invalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			s1_center <= cwrap[wmf_pkg::PTR_W-1:0];
			s1_border <= !interior;
			s1_last   <= frame_last;
		end
	end

	// One line-store copy per window row
	for (genvar k = 0; k < wmf_pkg::WIN_SIDE; k++) begin : g_row
		localparam int DR = k - wmf_pkg::MAX_RADIUS;
		logic [SW-1:0]                 row_off;
		logic [SW-1:0]                 a_raw;
		logic [wmf_pkg::PTR_W-1:0]     a_wrap;
		wmf_pkg::pix_t                 rdata;

		assign row_off = SW'(DR * int'(w_eff));
		assign a_raw   = SW'(s1_center) + row_off + dc;

		always_comb begin
			if (a_raw[SW-1]) begin
				a_wrap = wmf_pkg::PTR_W'(a_raw + SW'(wmf_pkg::STORE_DEPTH));
			end else if (a_raw >= SW'(wmf_pkg::STORE_DEPTH)) begin
				a_wrap = wmf_pkg::PTR_W'(a_raw - SW'(wmf_pkg::STORE_DEPTH));
			end else begin
				a_wrap = a_raw[wmf_pkg::PTR_W-1:0];
			end
		end

		wmf_ram #(
			.WIDTH(wmf_pkg::PIX_W),
			.DEPTH(wmf_pkg::STORE_DEPTH)
		) u_store (
			.clk   (clk),
			.we    (in_fire && is_data),
			.waddr (wr_q),
			.wdata (pixel),
			.re    (s1_valid),
			.raddr (a_wrap),
			.rdata (rdata)
		);

		assign ram_col[k] = rdata;
	end

	// Track reads and the request whose window completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_s2 <= 1'b0;
			tag_s2   <= '0;
			tag_s3   <= '0;
		end else begin
			shift_s2      <= s1_valid;
			tag_s2.valid  <= s1_done;
			tag_s2.border <= s1_border;
			tag_s2.last   <= s1_last;
			tag_s3        <= tag_s2;
		end
	end

	// Window columns shift toward the oldest side
	for (genvar p = 0; p < wmf_pkg::WIN_SIDE; p++) begin : g_col
		wmf_pkg::col_t din;
		if (p == wmf_pkg::WIN_SIDE - 1) begin : g_lead
			assign din = ram_col;
		end else begin : g_mid
			assign din = chain[p + 1];
		end
		wmf_cell u_col (
			.clk   (clk),
			.shift (shift_s2),
			.din   (din),
			.q     (chain[p])
		);
	end

	wmf_mode u_mode (
		.clk     (clk),
		.arst_n  (arst_n),
		.win     (chain),
		.tag_in  (tag_s3),
		.radius  (r_eff),
		.tag_out (mode_tag),
		.value   (mode_value)
	);

	// Output queue and credit count
	assign out_valid = (fcnt_q != '0);
	assign pop       = out_valid && !out_stall;
	assign out_pixel = fifo_pix_q[frp_q];
	assign out_last  = fifo_last_q[frp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwp_q   <= '0;
			frp_q   <= '0;
			fcnt_q  <= '0;
			outst_q <= '0;
		end else begin
			if (mode_tag.valid) begin
				fwp_q <= fwp_q + wmf_pkg::FIFO_AW'(1);
			end
			if (pop) begin
				frp_q <= frp_q + wmf_pkg::FIFO_AW'(1);
			end
			fcnt_q  <= fcnt_q + (wmf_pkg::FIFO_AW + 1)'(mode_tag.valid) -
				(wmf_pkg::FIFO_AW + 1)'(pop);
			outst_q <= outst_q + (wmf_pkg::FIFO_AW + 1)'(emit_fire) -
				(wmf_pkg::FIFO_AW + 1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (mode_tag.valid) begin
			fifo_pix_q[fwp_q]  <= mode_value;
			fifo_last_q[fwp_q] <= mode_tag.last;
		end
	end

	// Queue holds no more than the requests in flight
	a_fifo_credit: assert property (@(posedge clk) disable iff (!arst_n)
		fcnt_q <= outst_q)
		else $error("output queue exceeds outstanding count");

	// A reload runs only for a held request
	a_refill_held: assert property (@(posedge clk) disable iff (!arst_n)
		refill_q |-> s1_valid)
		else $error("reload without a request");

	// A request under reload keeps its center
	a_center_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid && !g_last) |=> (s1_valid && $stable(s1_center)))
		else $error("center changed during reload");

	// Pending pixels stay within the store lag
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= wmf_pkg::PEND_W'(wmf_pkg::LAG_MAX))
		else $error("pending count out of range");

endmodule

/* hw/rtl/wmf_ram.sv */
module wmf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port, registered read port returning the old word on a collision
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/wmf_cell.sv */
module wmf_cell (
	input  logic          clk,
	input  logic          shift,
	input  wmf_pkg::col_t din,
	output wmf_pkg::col_t q
);

	wmf_pkg::col_t col_q;

	// Take the neighbor's column on each shift
	always_ff @(posedge clk) begin
		if (shift) begin
			col_q <= din;
		end
	end

	assign q = col_q;

endmodule

/* hw/rtl/wmf_mode.sv */
module wmf_mode (
	input  logic                        clk,
	input  logic                        arst_n,
	input  wmf_pkg::col_t               win [wmf_pkg::WIN_SIDE],
	input  wmf_pkg::tag_t               tag_in,
	input  logic [wmf_pkg::RAD_W-1:0]   radius,
	output wmf_pkg::tag_t               tag_out,
	output wmf_pkg::pix_t               value
);

	wmf_pkg::pix_t                      vals [wmf_pkg::WIN_CELLS];
	logic                               act [wmf_pkg::WIN_CELLS];
	logic [wmf_pkg::PART_W-1:0]         part_d [wmf_pkg::WIN_CELLS][wmf_pkg::WIN_SIDE];
	logic [wmf_pkg::GATHER_W-1:0]       cpos;
	wmf_pkg::pix_t                      center_d;

	logic [wmf_pkg::PART_W-1:0]         part_s1 [wmf_pkg::WIN_CELLS][wmf_pkg::WIN_SIDE];
	wmf_pkg::pix_t                      vals_s1 [wmf_pkg::WIN_CELLS];
	logic                               act_s1 [wmf_pkg::WIN_CELLS];
	wmf_pkg::pix_t                      center_s1;
	wmf_pkg::tag_t                      tag_s1;

	logic [wmf_pkg::CNT_W-1:0]          cnt_d [wmf_pkg::WIN_CELLS];
	logic [wmf_pkg::CNT_W-1:0]          cnt_s2 [wmf_pkg::WIN_CELLS];
	wmf_pkg::pix_t                      vals_s2 [wmf_pkg::WIN_CELLS];
	wmf_pkg::pix_t                      center_s2;
	wmf_pkg::tag_t                      tag_s2;

	logic [wmf_pkg::CNT_W-1:0]          gcnt_d [wmf_pkg::WIN_SIDE];
	wmf_pkg::pix_t                      gval_d [wmf_pkg::WIN_SIDE];
	logic [wmf_pkg::CNT_W-1:0]          gcnt_s3 [wmf_pkg::WIN_SIDE];
	wmf_pkg::pix_t                      gval_s3 [wmf_pkg::WIN_SIDE];
	wmf_pkg::pix_t                      center_s3;
	wmf_pkg::tag_t                      tag_s3;

	wmf_pkg::pix_t                      mode_d;
	wmf_pkg::pix_t                      value_s4;
	wmf_pkg::tag_t                      tag_s4;

	// Flatten the window in row-major order and mark the cells in use
	always_comb begin
		for (int k = 0; k < wmf_pkg::WIN_SIDE; k++) begin
			for (int p = 0; p < wmf_pkg::WIN_SIDE; p++) begin
				vals[k * wmf_pkg::WIN_SIDE + p] = win[p][k];
				act[k * wmf_pkg::WIN_SIDE + p] =
					(k + int'(radius) >= wmf_pkg::MAX_RADIUS) &&
					(k <= wmf_pkg::MAX_RADIUS + int'(radius)) &&
					(p + 2 * int'(radius) >= wmf_pkg::WIN_SIDE - 1);
			end
		end
	end

	// Pick the center pixel for pass-through
	assign cpos = wmf_pkg::GATHER_W'(wmf_pkg::WIN_SIDE - 1) - wmf_pkg::GATHER_W'(radius);
	assign center_d = win[cpos][wmf_pkg::MAX_RADIUS];

	// Count matches per cell, one partial sum per window row
	always_comb begin
		logic [wmf_pkg::PART_W-1:0] acc;
		for (int i = 0; i < wmf_pkg::WIN_CELLS; i++) begin
			for (int g = 0; g < wmf_pkg::WIN_SIDE; g++) begin
				acc = '0;
				for (int m = 0; m < wmf_pkg::WIN_SIDE; m++) begin
					acc = acc + wmf_pkg::PART_W'(act[g * wmf_pkg::WIN_SIDE + m] &&
						(vals[g * wmf_pkg::WIN_SIDE + m] == vals[i]));
				end
				part_d[i][g] = acc;
			end
		end
	end

	// Total the partial counts, idle cells count zero
	always_comb begin
		logic [wmf_pkg::CNT_W-1:0] acc;
		for (int i = 0; i < wmf_pkg::WIN_CELLS; i++) begin
			acc = '0;
			for (int g = 0; g < wmf_pkg::WIN_SIDE; g++) begin
				acc = acc + wmf_pkg::CNT_W'(part_s1[i][g]);
			end
			cnt_d[i] = act_s1[i] ? acc : '0;
		end
	end

	// Best of each row group, earliest cell wins a tie
	always_comb begin
		for (int g = 0; g < wmf_pkg::WIN_SIDE; g++) begin
			gcnt_d[g] = '0;
			gval_d[g] = '0;
			for (int m = 0; m < wmf_pkg::WIN_SIDE; m++) begin
				if (cnt_s2[g * wmf_pkg::WIN_SIDE + m] > gcnt_d[g]) begin
					gcnt_d[g] = cnt_s2[g * wmf_pkg::WIN_SIDE + m];
					gval_d[g] = vals_s2[g * wmf_pkg::WIN_SIDE + m];
				end
			end
		end
	end

	// Best across the groups
	always_comb begin
		logic [wmf_pkg::CNT_W-1:0] best;
		best = '0;
		mode_d = '0;
		for (int g = 0; g < wmf_pkg::WIN_SIDE; g++) begin
			if (gcnt_s3[g] > best) begin
				best = gcnt_s3[g];
				mode_d = gval_s3[g];
			end
		end
	end

	// Advance the tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
		end else begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
		end
	end

	// Advance the data
	always_ff @(posedge clk) begin
		part_s1   <= part_d;
		vals_s1   <= vals;
		act_s1    <= act;
		center_s1 <= center_d;
		cnt_s2    <= cnt_d;
		vals_s2   <= vals_s1;
		center_s2 <= center_s1;
		gcnt_s3   <= gcnt_d;
		gval_s3   <= gval_d;
		center_s3 <= center_s2;
		value_s4  <= tag_s3.border ? center_s3 : mode_d;
	end

	assign tag_out = tag_s4;
	assign value   = value_s4;

endmodule

/* sim/window_mode_filter_tb.sv */
`timescale 1ns / 1ps

module window_mode_filter_tb;

	typedef struct {
		wmf_pkg::pix_t px;
		logic          last;
	} filt_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [wmf_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [wmf_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                           in_valid = 1'b0;
	logic                           in_stall;
	logic                           mode = wmf_pkg::MODE_PIXEL;
	wmf_pkg::pix_t                  pixel = '0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	wmf_pkg::pix_t                  out_pixel;
	logic                           out_last;

	// Predictor state
	wmf_pkg::pix_t                 store_px [wmf_pkg::STORE_DEPTH];
	int                            wr_pos;
	int                            held_px;
	int                            ocol;
	int                            orow;
	logic [wmf_pkg::WIDTH_W-1:0]   reg_width;
	logic [wmf_pkg::HEIGHT_W-1:0]  reg_height;
	logic [wmf_pkg::RADIUS_W-1:0]  reg_radius;
	filt_t                         expected_px [$];

	int  mismatches = 0;
	bit  quiet = 1'b0;
	bit  hold_req = 1'b0;
	int  pixels_sent = 0;

	window_mode_filter DUT (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic int eff_w();
		if (reg_width == 0) return 1;
		return (reg_width > wmf_pkg::MAX_WIDTH) ? wmf_pkg::MAX_WIDTH : int'(reg_width);
	endfunction

	function automatic int eff_h();
		return (reg_height == 0) ? 1 : int'(reg_height);
	endfunction

	// Filter the pixel at the head of the held pixels and advance output position
	function automatic void emit_filtered();
		int            w, h, r, center, n, addr, best_cnt;
		int            tally [256];
		wmf_pkg::pix_t cells [wmf_pkg::WIN_CELLS];
		filt_t         res;
		w = eff_w();
		h = eff_h();
		r = int'(reg_radius);
		center = (wr_pos + wmf_pkg::STORE_DEPTH - held_px) % wmf_pkg::STORE_DEPTH;
		if (orow >= r && orow + r < h && ocol >= r && ocol + r < w) begin
			n = 0;
			foreach (tally[i]) tally[i] = 0;
			for (int dr = -r; dr <= r; dr++)
				for (int dc = -r; dc <= r; dc++) begin
					addr = (center + wmf_pkg::STORE_DEPTH + dr * w + dc) % wmf_pkg::STORE_DEPTH;
					cells[n] = store_px[addr];
					tally[cells[n]]++;
					n++;
				end
			best_cnt = 0;
			res.px = '0;
			for (int i = 0; i < n; i++)
				if (tally[cells[i]] > best_cnt) begin
					best_cnt = tally[cells[i]];
					res.px = cells[i];
				end
		end else begin
			res.px = store_px[center];
		end
		res.last = (orow == h - 1 && ocol == w - 1);
		expected_px.push_back(res);
		ocol++;
		if (ocol >= w) begin
			ocol = 0;
			orow++;
			if (orow >= h) orow = 0;
		end
	endfunction

	function automatic void predict_request(logic m, wmf_pkg::pix_t p);
		int r;
		r = int'(reg_radius);
		if (m == wmf_pkg::MODE_PIXEL) begin
			store_px[wr_pos] = p;
			wr_pos = (wr_pos + 1) % wmf_pkg::STORE_DEPTH;
			held_px++;
			if (held_px > r * eff_w() + r) begin
				emit_filtered();
				held_px--;
			end
		end else if (held_px > 0) begin
			emit_filtered();
			held_px--;
		end
	endfunction

	// Offer one request and wait for it to be taken
	task automatic send_request(logic m, wmf_pkg::pix_t p);
		int gap;
		gap = quiet ? 0 : int'($urandom_range(0, 17));
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		pixel <= p;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_request(m, p);
		if (m == wmf_pkg::MODE_PIXEL) pixels_sent++;
	endtask

	task automatic send_pixel(wmf_pkg::pix_t p);
		send_request(wmf_pkg::MODE_PIXEL, p);
	endtask

	// Drain outstanding results, then let the pipeline settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_px.size() > 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(wmf_pkg::cfg_idx_t idx, logic [wmf_pkg::CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			wmf_pkg::CFG_WIDTH:  reg_width = val[wmf_pkg::WIDTH_W-1:0];
			wmf_pkg::CFG_HEIGHT: reg_height = val[wmf_pkg::HEIGHT_W-1:0];
			wmf_pkg::CFG_RADIUS: reg_radius = val[wmf_pkg::RADIUS_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_geometry(int w, int h, int r);
		write_reg(wmf_pkg::CFG_WIDTH, wmf_pkg::CFG_DATA_W'(w));
		write_reg(wmf_pkg::CFG_HEIGHT, wmf_pkg::CFG_DATA_W'(h));
		write_reg(wmf_pkg::CFG_RADIUS, wmf_pkg::CFG_DATA_W'(r));
	endtask

	// Drain held pixels and walk output position back to frame start
	task automatic align_frame();
		while (held_px != 0 || ocol != 0 || orow != 0) begin
			if (held_px == 0) send_pixel(wmf_pkg::pix_t'($urandom_range(0, 255)));
			else send_request(wmf_pkg::MODE_FLUSH, '0);
		end
		wait_idle();
	endtask

	function automatic wmf_pkg::pix_t draw_pixel(bit narrow);
		wmf_pkg::pix_t choice [4] = '{8'h00, 8'hFF, 8'h5A, 8'hA5};
		return narrow ? choice[$urandom_range(0, 3)] : wmf_pkg::pix_t'($urandom_range(0, 255));
	endfunction

	// Write every store entry once so later windows never read stale power-up data
	task automatic test_fill_store();
		quiet = 1'b1;
		for (int i = 0; i < wmf_pkg::STORE_DEPTH; i++) send_pixel(draw_pixel(i[4]));
		send_request(wmf_pkg::MODE_FLUSH, '0);
		wait_idle();
		quiet = 1'b0;
		set_geometry(3, 3, 1);
		align_frame();
	endtask

	// Small frames with ties, extreme values and back-to-back frames
	task automatic test_directed();
		wmf_pkg::pix_t tie_frame [9] =
			'{8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h10, 8'h20, 8'h30};
		for (int f = 0; f < 2; f++)
			foreach (tie_frame[i]) send_pixel(f ? ~tie_frame[i] : tie_frame[i]);
		// flush in mid-frame, then finish the frame
		send_pixel(8'h80);
		send_request(wmf_pkg::MODE_FLUSH, '0);
		send_request(wmf_pkg::MODE_FLUSH, '0);
		send_request(wmf_pkg::MODE_FLUSH, '0);
		wait_idle();
		align_frame();
	endtask

	// Out-of-range and limit register values
	task automatic test_register_limits();
		set_geometry(0, 0, 0);
		for (int i = 0; i < 6; i++) send_pixel(draw_pixel(1'b0));
		wait_idle();
		set_geometry(2047, 3, 3);
		quiet = 1'b1;
		for (int i = 0; i < 3 * wmf_pkg::MAX_WIDTH; i++) send_pixel(draw_pixel(1'b0));
		wait_idle();
		set_geometry(wmf_pkg::MAX_WIDTH, 7, 3);
		align_frame();
		for (int i = 0; i < 7 * wmf_pkg::MAX_WIDTH; i++) send_pixel(draw_pixel(i[6]));
		send_request(wmf_pkg::MODE_FLUSH, '0);
		wait_idle();
		quiet = 1'b0;
		// registers changed with pixels still held
		set_geometry(5, 65535, 2);
		for (int i = 0; i < 20; i++) send_pixel(draw_pixel(1'b1));
		wait_idle();
		set_geometry(4, 4, 1);
		align_frame();
	endtask

	// Stall the output long enough for the block to back up its input
	task automatic test_backpressure();
		set_geometry(6, 5, 1);
		align_frame();
		quiet = 1'b1;
		hold_req = 1'b1;
		for (int i = 0; i < 90; i++) send_pixel(draw_pixel(1'b1));
		quiet = 1'b0;
		wait_idle();
		align_frame();
	endtask

	// Random geometry, mostly whole frames, with stray flushes and held-pixel reconfigs
	task automatic test_random_frames();
		int w, h, r, base;
		base = pixels_sent;
		while (pixels_sent - base < 1900) begin
			w = ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, 64)) :
				int'($urandom_range(1, 12));
			h = int'($urandom_range(1, 10));
			r = int'($urandom_range(0, 3));
			set_geometry(w, h, r);
			if ($urandom_range(0, 3) != 0) align_frame();
			quiet = ($urandom_range(0, 4) == 0);
			repeat ($urandom_range(1, 3)) begin
				for (int i = 0; i < w * h; i++) begin
					send_pixel(draw_pixel(bit'($urandom_range(0, 1))));
					if ($urandom_range(0, 40) == 0)
						send_request(wmf_pkg::MODE_FLUSH, wmf_pkg::pix_t'($urandom));
				end
			end
			repeat ($urandom_range(0, r * w + r + 2))
				send_request(wmf_pkg::MODE_FLUSH, wmf_pkg::pix_t'($urandom));
			quiet = 1'b0;
			wait_idle();
		end
	endtask

	// Accept and check results; pace the output side
	always @(posedge clk or negedge arst_n) begin
		int    stall_left;
		filt_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_px.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected output pixel %0d last %0b", out_pixel, out_last);
				end else begin
					want = expected_px.pop_front();
					if (out_pixel !== want.px || out_last !== want.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected pixel %0d last %0b, got %0d last %0b",
								want.px, want.last, out_pixel, out_last);
					end
				end
				stall_left = quiet ? 0 : int'($urandom_range(0, 17));
			end
			if (hold_req) begin
				stall_left = 300;
				hold_req = 1'b0;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		foreach (store_px[i]) store_px[i] = '0;
		wr_pos = 0;
		held_px = 0;
		ocol = 0;
		orow = 0;
		reg_width = wmf_pkg::WIDTH_RST;
		reg_height = wmf_pkg::HEIGHT_RST;
		reg_radius = wmf_pkg::RADIUS_RST;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fill_store();
		test_directed();
		test_register_limits();
		test_backpressure();
		test_random_frames();
		wait_idle();
		repeat (50) @(posedge clk);
		if (mismatches == 0 && expected_px.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

/* files.f */
hw/rtl/wmf_pkg.sv
hw/rtl/wmf_ram.sv
hw/rtl/wmf_cell.sv
hw/rtl/wmf_mode.sv
hw/rtl/window_mode_filter.sv
sim/window_mode_filter_tb.sv
